/* sv/odp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odp_pkg
// Shared types, constants and helpers of the ordered-dither 1-bit packer.
// ----------------------------------------------------------------------------
package odp_pkg;

  localparam int unsigned MAX_TABLE_DIM_DEF  = 16;
  localparam int unsigned MAX_LINE_WIDTH_DEF = 4096;
  localparam int unsigned MAX_LINES_DEF      = 4096;

  localparam int unsigned CFG_DW      = 13;
  localparam int unsigned CFG_IW      = 2;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned BYTE_LAST   = 7;
  localparam int unsigned BCNT_W      = $clog2(BYTE_BITS);
  localparam int unsigned TABLE_RST   = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IW-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TABLE_WIDTH  = 2'd2,
    REG_TABLE_HEIGHT = 2'd3
  } odp_reg_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_PIXEL = 1'b1
  } odp_func_t;

  // control bits that travel with each request from front to back
  typedef struct packed {
    logic              is_load;
    logic [BCNT_W-1:0] bit_pos;
    logic              emit;
    logic              row_end;
    logic              frame_end;
  } odp_ctl_t;

  function automatic int unsigned cnt_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // zero acts as one, anything above the bound acts as the bound
  function automatic logic [31:0] clamp_reg(logic [CFG_DW-1:0] v, logic [31:0] hi);
    logic [31:0] r;
    if (v == '0) begin
      r = 32'd1;
    end else if (32'(v) > hi) begin
      r = hi;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

/* sv/odp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odp_front
// Accepts requests, holds configuration and raster position, and turns each
// request into a store write or a threshold lookup with its packing flags.
// ----------------------------------------------------------------------------
module odp_front #(
  parameter int unsigned MAX_TABLE_DIM  = odp_pkg::MAX_TABLE_DIM_DEF,
  parameter int unsigned MAX_LINE_WIDTH = odp_pkg::MAX_LINE_WIDTH_DEF,
  parameter int unsigned MAX_LINES      = odp_pkg::MAX_LINES_DEF,
  parameter int unsigned AW             = odp_pkg::cnt_w(MAX_TABLE_DIM * MAX_TABLE_DIM)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [odp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [odp_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [odp_pkg::PIX_W-1:0]   in_pixel,
  input  logic [odp_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [odp_pkg::PIX_W-1:0]   in_entry_value,
  output logic                        push_valid,
  input  logic                        push_ready,
  output odp_pkg::odp_ctl_t           push_ctl,
  output logic [AW-1:0]               push_addr,
  output logic [odp_pkg::PIX_W-1:0]   push_data
);
  import odp_pkg::*;

  localparam int unsigned LW  = cnt_w(MAX_LINE_WIDTH);
  localparam int unsigned LCW = LW + 1;
  localparam int unsigned RW  = cnt_w(MAX_LINES);
  localparam int unsigned RCW = RW + 1;
  localparam int unsigned TW  = cnt_w(MAX_TABLE_DIM);
  localparam int unsigned TCW = TW + 1;
  localparam int unsigned TBL_REG_W = 5;
  localparam int unsigned STORE_DEPTH = MAX_TABLE_DIM * MAX_TABLE_DIM;
  localparam int unsigned TBL_RST = (TABLE_RST > MAX_TABLE_DIM) ? MAX_TABLE_DIM : TABLE_RST;

  logic [LCW-1:0]    img_w_r, img_w_nxt;
  logic [RCW-1:0]    img_h_r, img_h_nxt;
  logic [TCW-1:0]    tbl_w_r, tbl_w_nxt;
  logic [TCW-1:0]    tbl_h_r, tbl_h_nxt;
  logic [LW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [TW-1:0]     tcol_r, tcol_nxt;
  logic [TW-1:0]     trow_r, trow_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;

  logic              is_pixel;
  logic              load_ok;
  logic              pix_step;
  logic [LCW-1:0]    col_inc;
  logic [RCW-1:0]    row_inc;
  logic [TCW-1:0]    tcol_inc;
  logic [TCW-1:0]    trow_inc;
  logic [TW-1:0]     tcol_wrap;
  logic [TW-1:0]     trow_wrap;
  logic              at_row_end;
  logic              at_frame_end;
  logic              emit;
  logic [TW+TCW-1:0] row_base;
  logic [TW+TCW:0]   addr_full;
  logic [CFG_DW-1:0] cfg_tbl;

  assign is_pixel = (odp_func_t'(in_func) == FUNC_PIXEL);
  assign load_ok  = 32'(in_entry_index) < 32'(STORE_DEPTH);

  // matrix size registers keep only their low five bits
  assign cfg_tbl  = CFG_DW'(cfg_data[TBL_REG_W-1:0]);

  assign col_inc      = LCW'(col_r) + LCW'(1);
  assign row_inc      = RCW'(row_r) + RCW'(1);
  assign at_row_end   = (col_inc >= img_w_r);
  assign at_frame_end = at_row_end && (row_inc >= img_h_r);
  assign emit         = at_row_end || (bcnt_r == BCNT_W'(BYTE_LAST));

  assign tcol_inc  = TCW'(tcol_r) + TCW'(1);
  assign trow_inc  = TCW'(trow_r) + TCW'(1);
  assign tcol_wrap = (tcol_inc >= tbl_w_r) ? '0 : tcol_inc[TW-1:0];
  assign trow_wrap = (trow_inc >= tbl_h_r) ? '0 : trow_inc[TW-1:0];

  // small multiply: matrix row times matrix width
  assign row_base  = trow_r * tbl_w_r;
  assign addr_full = (TW+TCW+1)'(row_base) + (TW+TCW+1)'(tcol_r);

  assign in_ready   = push_ready;
  assign push_valid = in_valid && (is_pixel || load_ok);
  assign push_addr  = is_pixel ? AW'(addr_full) : AW'(in_entry_index);
  assign push_data  = is_pixel ? in_pixel : in_entry_value;
  assign pix_step   = in_valid && push_ready && is_pixel;

  always_comb begin
    push_ctl           = '0;
    push_ctl.is_load   = !is_pixel;
    push_ctl.bit_pos   = bcnt_r;
    push_ctl.emit      = emit;
    push_ctl.row_end   = at_row_end;
    push_ctl.frame_end = at_frame_end;
  end

  always_comb begin
    img_w_nxt = img_w_r;
    img_h_nxt = img_h_r;
    tbl_w_nxt = tbl_w_r;
    tbl_h_nxt = tbl_h_r;
    if (cfg_wr_en) begin
      unique case (odp_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  img_w_nxt = LCW'(clamp_reg(cfg_data, 32'(MAX_LINE_WIDTH)));
        REG_IMAGE_HEIGHT: img_h_nxt = RCW'(clamp_reg(cfg_data, 32'(MAX_LINES)));
        REG_TABLE_WIDTH:  tbl_w_nxt = TCW'(clamp_reg(cfg_tbl, 32'(MAX_TABLE_DIM)));
        REG_TABLE_HEIGHT: tbl_h_nxt = TCW'(clamp_reg(cfg_tbl, 32'(MAX_TABLE_DIM)));
      endcase
    end
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    tcol_nxt = tcol_r;
    trow_nxt = trow_r;
    bcnt_nxt = bcnt_r;
    if (pix_step) begin
      if (emit) begin
        bcnt_nxt = '0;
        if (at_row_end) begin
          col_nxt  = '0;
          tcol_nxt = '0;
          if (at_frame_end) begin
            row_nxt  = '0;
            trow_nxt = '0;
          end else begin
            row_nxt  = row_inc[RW-1:0];
            trow_nxt = trow_wrap;
          end
        end else begin
          col_nxt  = col_inc[LW-1:0];
          tcol_nxt = tcol_wrap;
        end
      end else begin
        bcnt_nxt = bcnt_r + BCNT_W'(1);
        col_nxt  = col_inc[LW-1:0];
        tcol_nxt = tcol_wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= LCW'(1);
      img_h_r <= RCW'(1);
      tbl_w_r <= TCW'(TBL_RST);
      tbl_h_r <= TCW'(TBL_RST);
      col_r   <= '0;
      row_r   <= '0;
      tcol_r  <= '0;
      trow_r  <= '0;
      bcnt_r  <= '0;
    end else begin
      img_w_r <= img_w_nxt;
      img_h_r <= img_h_nxt;
      tbl_w_r <= tbl_w_nxt;
      tbl_h_r <= tbl_h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      tcol_r  <= tcol_nxt;
      trow_r  <= trow_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

endmodule

/* sv/odp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odp_queue
// Short register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module odp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = odp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import odp_pkg::*;

  localparam int unsigned PW = cnt_w(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* sv/odp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odp_back
// Threshold store, compare and bit packing, with the output register.
// ----------------------------------------------------------------------------
module odp_back #(
  parameter int unsigned MAX_TABLE_DIM = odp_pkg::MAX_TABLE_DIM_DEF,
  parameter int unsigned AW            = odp_pkg::cnt_w(MAX_TABLE_DIM * MAX_TABLE_DIM)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  odp_pkg::odp_ctl_t           pop_ctl,
  input  logic [AW-1:0]               pop_addr,
  input  logic [odp_pkg::PIX_W-1:0]   pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [odp_pkg::BYTE_BITS-1:0] out_packed_byte,
  output logic                        out_row_end,
  output logic                        out_frame_end
);
  import odp_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_TABLE_DIM * MAX_TABLE_DIM;

  logic [PIX_W-1:0]     store_mem [STORE_DEPTH];
  logic [PIX_W-1:0]     rd_data_r;
  logic                 s1_valid_r, s1_valid_nxt;
  odp_ctl_t             s1_ctl_r;
  logic [PIX_W-1:0]     s1_pix_r;
  logic [BYTE_BITS-1:0] acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_BITS-1:0] out_byte_r;
  logic                 out_row_end_r;
  logic                 out_frame_end_r;

  logic                 stall;
  logic                 pop;
  logic                 wr_en;
  logic                 rd_en;
  logic                 consume;
  logic                 hit;
  logic [BYTE_BITS-1:0] acc_new;

  // only an emitting pixel against a full, blocked output register waits
  assign stall     = s1_valid_r && s1_ctl_r.emit && out_valid_r && !out_ready;
  assign pop_ready = !stall;
  assign pop       = pop_valid && !stall;
  assign wr_en     = pop && pop_ctl.is_load;
  assign rd_en     = pop && !pop_ctl.is_load;
  assign consume   = s1_valid_r && !stall;

  assign hit     = (s1_pix_r > rd_data_r);
  assign acc_new = acc_r | (hit ? (BYTE_BITS'(8'h80) >> s1_ctl_r.bit_pos) : '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[pop_addr] <= pop_data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[pop_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_ctl_r <= pop_ctl;
      s1_pix_r <= pop_data;
    end
    if (consume && s1_ctl_r.emit) begin
      out_byte_r      <= acc_new;
      out_row_end_r   <= s1_ctl_r.row_end;
      out_frame_end_r <= s1_ctl_r.frame_end;
    end
  end

  always_comb begin
    s1_valid_nxt  = stall ? s1_valid_r : rd_en;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (consume) begin
      acc_nxt = s1_ctl_r.emit ? '0 : acc_new;
      if (s1_ctl_r.emit) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_byte = out_byte_r;
  assign out_row_end     = out_row_end_r;
  assign out_frame_end   = out_frame_end_r;

endmodule

/* sv/ordered_dither_pack_1bit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_dither_pack_1bit
// Ordered-dither halftoning of 8-bit grey pixels into MSB-first packed bytes.
// ----------------------------------------------------------------------------
// Takes one request per clock, load or pixel, while the queue has room; the
// figure is set by the single-port threshold store, which serves one write or
// one read a cycle. An accepted pixel passes the queue, then a registered store
// read from the queue head, then compare and pack into the output register.
// The front keeps the raster and matrix positions and a four-entry queue lets
// it run ahead of a stalled output. The threshold store has no reset and needs
// no clearing: entries must be loaded before pixels use them.
module ordered_dither_pack_1bit #(
  parameter int unsigned MAX_TABLE_DIM  = odp_pkg::MAX_TABLE_DIM_DEF,
  parameter int unsigned MAX_LINE_WIDTH = odp_pkg::MAX_LINE_WIDTH_DEF,
  parameter int unsigned MAX_LINES      = odp_pkg::MAX_LINES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [odp_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [odp_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [odp_pkg::PIX_W-1:0]     in_pixel,
  input  logic [odp_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [odp_pkg::PIX_W-1:0]     in_entry_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [odp_pkg::BYTE_BITS-1:0] out_packed_byte,
  output logic                          out_row_end,
  output logic                          out_frame_end
);
  import odp_pkg::*;

  localparam int unsigned AW = cnt_w(MAX_TABLE_DIM * MAX_TABLE_DIM);
  localparam int unsigned QW = $bits(odp_ctl_t) + AW + PIX_W;

  logic             push_valid;
  logic             push_ready;
  odp_ctl_t         push_ctl;
  logic [AW-1:0]    push_addr;
  logic [PIX_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [QW-1:0]    pop_word;
  odp_ctl_t         pop_ctl;
  logic [AW-1:0]    pop_addr;
  logic [PIX_W-1:0] pop_data;

  odp_front #(
    .MAX_TABLE_DIM  (MAX_TABLE_DIM),
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .MAX_LINES      (MAX_LINES),
    .AW             (AW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_pixel       (in_pixel),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_ctl       (push_ctl),
    .push_addr      (push_addr),
    .push_data      (push_data)
  );

  odp_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_ctl, push_addr, push_data}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_word)
  );

  assign {pop_ctl, pop_addr, pop_data} = pop_word;

  odp_back #(
    .MAX_TABLE_DIM (MAX_TABLE_DIM),
    .AW            (AW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_ctl         (pop_ctl),
    .pop_addr        (pop_addr),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_byte (out_packed_byte),
    .out_row_end     (out_row_end),
    .out_frame_end   (out_frame_end)
  );

endmodule

/* sv/odp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odp_checker
// Port-level checks of the dither packer, bound to the top level.
// ----------------------------------------------------------------------------
module odp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [odp_pkg::BYTE_BITS-1:0] out_packed_byte,
  input logic                          out_row_end,
  input logic                          out_frame_end
);

  // a frame always closes on a row boundary
  a_frame_on_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_end || !out_frame_end))
    else $error("frame end without row end");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_packed_byte) && $stable(out_row_end)
       && $stable(out_frame_end)))
    else $error("stalled result changed");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // queue comes out of reset empty, so requests are taken at once
  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("not ready after reset");

endmodule

bind ordered_dither_pack_1bit odp_checker u_odp_checker (.*);

/* dv/dither_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dither_checker
// Monitors the request, result and register ports of the ordered-dither
// packer. Keeps its own copy of the threshold store, the raster and matrix
// positions and the partial byte, predicts every packed byte and compares
// each returned byte against the oldest prediction still pending.
// ----------------------------------------------------------------------------
module dither_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [odp_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [odp_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_func,
  input  logic [odp_pkg::PIX_W-1:0]     in_pixel,
  input  logic [odp_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [odp_pkg::PIX_W-1:0]     in_entry_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [odp_pkg::BYTE_BITS-1:0] out_packed_byte,
  input  logic                          out_row_end,
  input  logic                          out_frame_end,
  output int                            err_count,
  output int                            pending
);
  import odp_pkg::*;

  typedef struct packed {
    logic [BYTE_BITS-1:0] bits;
    logic                 row_end;
    logic                 frame_end;
  } halftone_byte_t;

  logic [PIX_W-1:0]  thr_mem [MAX_TABLE_DIM_DEF*MAX_TABLE_DIM_DEF];
  logic [CFG_DW-1:0] img_w, img_h;
  logic [4:0]        tbl_w, tbl_h;
  logic [11:0]       col_pos, row_pos;
  logic [3:0]        tbl_col, tbl_row;
  logic [7:0]        acc;
  logic [2:0]        nbits;

  halftone_byte_t expected_bytes [$];
  int errors = 0;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  // zero behaves as one, anything past the limit behaves as the limit
  function automatic int unsigned bound_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned step_wrap(input int unsigned p, input int unsigned lim);
    return (p + 1 >= lim) ? 0 : p + 1;
  endfunction

  // one pixel through the threshold compare and the bit packer
  function automatic bit halftone_pixel(input logic [7:0] pix, output halftone_byte_t res);
    int unsigned w, h, tw, th, addr, col, row;
    bit row_done, frame_done;
    w    = bound_reg(32'(img_w), MAX_LINE_WIDTH_DEF);
    h    = bound_reg(32'(img_h), MAX_LINES_DEF);
    tw   = bound_reg(32'(tbl_w), MAX_TABLE_DIM_DEF);
    th   = bound_reg(32'(tbl_h), MAX_TABLE_DIM_DEF);
    col  = 32'(col_pos);
    row  = 32'(row_pos);
    addr = 32'(tbl_row) * tw + 32'(tbl_col);
    res  = '0;
    if (pix > thr_mem[addr]) acc[BYTE_LAST - 32'(nbits)] = 1'b1;
    row_done   = (col + 1 >= w);
    frame_done = row_done && (row + 1 >= h);
    if (row_done || nbits == 3'(BYTE_LAST)) begin
      res.bits      = acc;
      res.row_end   = row_done;
      res.frame_end = frame_done;
      acc   = '0;
      nbits = '0;
      if (row_done) begin
        col_pos = '0;
        tbl_col = '0;
        if (frame_done) begin
          row_pos = '0;
          tbl_row = '0;
        end else begin
          row_pos = 12'(row + 1);
          tbl_row = 4'(step_wrap(32'(tbl_row), th));
        end
      end else begin
        col_pos = 12'(col + 1);
        tbl_col = 4'(step_wrap(32'(tbl_col), tw));
      end
      return 1'b1;
    end
    nbits   = nbits + 3'd1;
    col_pos = 12'(col + 1);
    tbl_col = 4'(step_wrap(32'(tbl_col), tw));
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    halftone_byte_t want, got;
    if (!rst_n) begin
      img_w   = CFG_DW'(1);
      img_h   = CFG_DW'(1);
      tbl_w   = 5'(TABLE_RST);
      tbl_h   = 5'(TABLE_RST);
      col_pos = '0;
      row_pos = '0;
      tbl_col = '0;
      tbl_row = '0;
      acc     = '0;
      nbits   = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  img_w = cfg_data;
          REG_IMAGE_HEIGHT: img_h = cfg_data;
          REG_TABLE_WIDTH:  tbl_w = cfg_data[4:0];
          REG_TABLE_HEIGHT: tbl_h = cfg_data[4:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        got.bits      = out_packed_byte;
        got.row_end   = out_row_end;
        got.frame_end = out_frame_end;
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: byte with none pending: expected none, actual %h row_end %b %s%b",
                   $time, got.bits, got.row_end, "frame_end ", got.frame_end);
        end else begin
          want = expected_bytes.pop_front();
          if (got.bits != want.bits || got.row_end != want.row_end ||
              got.frame_end != want.frame_end) begin
            errors++;
            $display("%0t: byte mismatch: expected %h row_end %b frame_end %b,",
                     $time, want.bits, want.row_end, want.frame_end);
            $display("%0t:   actual %h row_end %b frame_end %b",
                     $time, got.bits, got.row_end, got.frame_end);
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_func == FUNC_LOAD) begin
          thr_mem[in_entry_index] = in_entry_value;
        end else if (halftone_pixel(in_pixel, want)) begin
          expected_bytes.push_back(want);
        end
      end
    end
    pending   <= expected_bytes.size();
    err_count <= errors;
  end

endmodule

/* dv/tb_ordered_dither_pack_1bit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_dither_pack_1bit
// Stimulus for the ordered-dither packer: fills the threshold store, runs a
// few directed threshold compares, then random pixel and load requests over a
// series of image and matrix sizes, including zero and oversized registers
// and a size change in the middle of a row. Checking is done by
// dither_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_ordered_dither_pack_1bit;
  import odp_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 5000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  odp_reg_t             cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DW-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  odp_func_t            in_func = FUNC_LOAD;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic [IDX_W-1:0]     in_entry_index = '0;
  logic [PIX_W-1:0]     in_entry_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_BITS-1:0] out_packed_byte;
  logic                 out_row_end;
  logic                 out_frame_end;

  int err_count;
  int pending;
  int snd_idle_pct = 7;
  int rcv_idle_pct = 60;
  int quiet_cycles = 0;

  ordered_dither_pack_1bit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_pixel        (in_pixel),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_byte (out_packed_byte),
    .out_row_end     (out_row_end),
    .out_frame_end   (out_frame_end)
  );

  dither_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_pixel        (in_pixel),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_byte (out_packed_byte),
    .out_row_end     (out_row_end),
    .out_frame_end   (out_frame_end),
    .err_count       (err_count),
    .pending         (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(input odp_func_t func, input logic [7:0] pix,
                              input logic [7:0] idx, input logic [7:0] val);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_pixel       <= pix;
    in_entry_index <= idx;
    in_entry_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // bytes still owed, then time for requests that make no byte to clear
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write enable stays up across back-to-back writes
  task automatic put_reg(input odp_reg_t r, input logic [CFG_DW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                           input logic [CFG_DW-1:0] tw, input logic [CFG_DW-1:0] th,
                           input int count);
    odp_func_t   func;
    logic [7:0]  pix;
    wait_idle();
    put_reg(REG_IMAGE_WIDTH, w);
    put_reg(REG_IMAGE_HEIGHT, h);
    put_reg(REG_TABLE_WIDTH, tw);
    put_reg(REG_TABLE_HEIGHT, th);
    cfg_wr_en <= 1'b0;
    repeat (count) begin
      func = ($urandom_range(99) < 12) ? FUNC_LOAD : FUNC_PIXEL;
      case ($urandom_range(7))
        0:       pix = 8'h00;
        1:       pix = 8'hFF;
        default: pix = 8'($urandom_range(255));
      endcase
      send_request(func, pix, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole store so no pixel ever reads an unwritten threshold
    for (int i = 0; i < 256; i++) begin
      send_request(FUNC_LOAD, 8'($urandom_range(255)), 8'(i), 8'(i) ^ 8'hA5);
    end

    // reset sizes: every pixel is a whole row and frame, always entry 0
    send_request(FUNC_LOAD, 8'h00, 8'h00, 8'h80);
    send_request(FUNC_PIXEL, 8'h80, 8'h00, 8'h00);
    send_request(FUNC_PIXEL, 8'h81, 8'hFF, 8'hFF);
    send_request(FUNC_LOAD, 8'hFF, 8'h00, 8'hFF);
    send_request(FUNC_PIXEL, 8'hFF, 8'h00, 8'h00);
    send_request(FUNC_PIXEL, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_LOAD, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_PIXEL, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_PIXEL, 8'h01, 8'h00, 8'h00);
    send_request(FUNC_PIXEL, 8'hFF, 8'h00, 8'h00);

    run_phase(13'd8, 13'd4, 13'd4, 13'd4, 80);
    run_phase(13'd13, 13'd3, 13'd16, 13'd16, 70);
    // zero registers behave as one
    run_phase(13'd0, 13'd0, 13'd0, 13'd0, 25);

    snd_idle_pct = 60;
    rcv_idle_pct = 7;
    run_phase(13'd4096, 13'd4096, 13'd16, 13'd16, 50);
    // shrink in the middle of a long row
    run_phase(13'd5, 13'd2, 13'd2, 13'd3, 50);
    // oversized registers clamp to the limits
    run_phase(13'd8191, 13'd8191, 13'd31, 13'd31, 40);
    run_phase(13'd1, 13'd7, 13'd5, 13'd1, 40);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(13'd20, 13'd5, 13'd7, 13'd9, 120);
    run_phase(13'd3, 13'd4096, 13'd1, 13'd16, 60);
    run_phase(13'd9, 13'd6, 13'd17, 13'd20, 80);

    wait_idle();
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
